// ----- src/a64lsu_pkg.sv -----
// Shared types, encodings and constants of the A64 load/store address unit.
`default_nettype none

package a64lsu_pkg;

    typedef enum logic [1:0] {
        STATUS_REJECT   = 2'd0,
        STATUS_ACCESS   = 2'd1,
        STATUS_PREFETCH = 2'd2
    } status_t;

    // Major opcode groups taken from instruction bits 29:24.
    localparam logic [5:0] GRP_ACQ_REL    = 6'h08;
    localparam logic [5:0] GRP_LIT_INT    = 6'h18;
    localparam logic [5:0] GRP_LIT_SIMD   = 6'h1C;
    localparam logic [5:0] GRP_PAIR_POST  = 6'h28;
    localparam logic [5:0] GRP_PAIR_OFF   = 6'h29;
    localparam logic [5:0] GRP_PAIR_VPOST = 6'h2C;
    localparam logic [5:0] GRP_PAIR_VOFF  = 6'h2D;
    localparam logic [5:0] GRP_INT_REG    = 6'h38;
    localparam logic [5:0] GRP_INT_UOFF   = 6'h39;
    localparam logic [5:0] GRP_SIMD_REG   = 6'h3C;
    localparam logic [5:0] GRP_SIMD_UOFF  = 6'h3D;

    localparam logic [31:0] ACQ_REL_MASK  = 32'h00BF_7C00;
    localparam logic [31:0] ACQ_REL_MATCH = 32'h009F_7C00;
    localparam logic [1:0]  REG_OFF_FORM  = 2'b10;
    localparam logic [2:0]  MAX_LOG_BYTES = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // One decoded instruction: a single access or a register pair.
    typedef struct packed {
        status_t     status;
        logic        is_load;
        logic        is_vector;
        logic [63:0] address;
        logic [4:0]  byte_count;
        logic [4:0]  reg_num;
        logic [4:0]  reg_num2;
        logic        sign_extend;
        logic        dest_is_64;
        logic        writeback_valid;
        logic [63:0] writeback_value;
        logic        pair;
    } plan_t;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        status_t     status;
        logic        is_load;
        logic        is_vector;
        logic [63:0] address;
        logic [4:0]  byte_count;
        logic [4:0]  reg_num;
        logic        sign_extend;
        logic        dest_is_64;
        logic        writeback_valid;
        logic [63:0] writeback_value;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ----- src/a64lsu_front.sv -----
// Front end: decodes the instruction word and computes the access plan.
`default_nettype none

module a64lsu_front (
    input  wire logic [31:0]       inst,
    input  wire logic [63:0]       pc,
    input  wire logic [63:0]       base_value,
    input  wire logic [63:0]       index_value,
    output a64lsu_pkg::plan_t      plan
);
    import a64lsu_pkg::*;

    logic [5:0]  group;
    logic [1:0]  size;
    logic [1:0]  opc;
    logic [2:0]  option;
    logic [4:0]  rn;
    logic [4:0]  rt;
    logic        load;
    logic        pre;
    logic        scaled;
    logic [2:0]  vscale;
    logic [63:0] imm9_ext;
    logic [63:0] lit_off;
    logic [63:0] imm12_ext;
    logic        int_ok;
    logic        int_ld;
    logic        int_d64;
    logic        pair_hit;

    logic        ok;
    logic        prefetch;
    logic        ld;
    logic        vec;
    logic        use_pc;
    logic        post;
    logic [63:0] off;
    logic [2:0]  blog;
    logic [4:0]  rt2;
    logic        sx;
    logic        d64;
    logic        wbv;
    logic        pair;
    logic [2:0]  scale;
    logic [63:0] sum;

    function automatic logic [63:0] extend_index(input logic [63:0] v,
                                                 input logic [2:0] opt,
                                                 input logic [2:0] shamt);
        logic [63:0] e;
        case (opt[1:0])
            2'd0: e = opt[2] ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
            2'd1: e = opt[2] ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
            2'd2: e = opt[2] ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
            default: e = v;
        endcase
        return e << shamt;
    endfunction

    assign group     = inst[29:24];
    assign size      = inst[31:30];
    assign opc       = inst[23:22];
    assign option    = inst[15:13];
    assign rn        = inst[9:5];
    assign rt        = inst[4:0];
    assign load      = inst[22];
    assign pre       = inst[11];
    assign scaled    = inst[12];
    assign vscale    = {inst[23], size};
    assign imm9_ext  = {{55{inst[20]}}, inst[20:12]};
    assign lit_off   = {{43{inst[23]}}, inst[23:5], 2'b00};
    assign imm12_ext = {52'd0, inst[21:10]};

    // Integer immediate forms: opc selects store, load or sign-extending load.
    assign int_ok  = !(opc[1] && (size == 2'd3 || (size == 2'd2 && opc[0])));
    assign int_ld  = opc[1] | opc[0];
    assign int_d64 = (size == 2'd3) || (opc[1] && !opc[0]);

    // A writeback pair may not name its own base as a target, except SP; only integer pairs check this.
    assign pair_hit = inst[23] && (rt == rn || inst[14:10] == rn) && rn != 5'd31;

    always_comb
    begin
        ok       = 1'b0;
        prefetch = 1'b0;
        ld       = 1'b0;
        vec      = 1'b0;
        use_pc   = 1'b0;
        post     = 1'b0;
        off      = '0;
        blog     = '0;
        rt2      = '0;
        sx       = 1'b0;
        d64      = 1'b0;
        wbv      = 1'b0;
        pair     = 1'b0;
        scale    = '0;
        case (group)
            GRP_ACQ_REL:
            begin
                ok   = (inst & ACQ_REL_MASK) == ACQ_REL_MATCH;
                ld   = load;
                post = 1'b1;
                blog = {1'b0, size};
                d64  = size == 2'd3;
            end
            GRP_LIT_INT:
            begin
                ok     = !inst[31];
                ld     = 1'b1;
                use_pc = 1'b1;
                off    = lit_off;
                blog   = inst[30] ? 3'd3 : 3'd2;
                d64    = inst[30];
            end
            GRP_LIT_SIMD:
            begin
                ok     = size != 2'd3;
                ld     = 1'b1;
                vec    = 1'b1;
                use_pc = 1'b1;
                off    = lit_off;
                blog   = 3'd2 + {1'b0, size};
            end
            GRP_PAIR_POST, GRP_PAIR_OFF, GRP_PAIR_VPOST, GRP_PAIR_VOFF:
            begin
                vec  = inst[26];
                rt2  = inst[14:10];
                wbv  = inst[23];
                post = !inst[24];
                ld   = load;
                pair = 1'b1;
                if (inst[26])
                begin
                    scale = 3'd2 + {1'b0, size};
                    ok    = !((!inst[24] && !inst[23]) || size == 2'd3 ||
                              (load && rt == inst[14:10]));
                end
                else
                begin
                    scale = inst[31] ? 3'd3 : 3'd2;
                    sx    = size[0];
                    d64   = size[1] | size[0];
                    ok    = !((!inst[24] && !inst[23]) || size == 2'd3 ||
                              (!load && size[0]) ||
                              (load && (rt == inst[14:10] || pair_hit)) ||
                              (!load && pair_hit));
                end
                off  = {{57{inst[21]}}, inst[21:15]} << scale;
                blog = scale;
            end
            GRP_INT_REG:
            begin
                blog = {1'b0, size};
                ld   = int_ld;
                sx   = opc[1];
                d64  = int_d64;
                if (inst[21])
                begin
                    ok  = inst[11:10] == REG_OFF_FORM && option[1] &&
                          !(opc[1] && opc[0] && size[1]);
                    prefetch = opc[1] && size == 2'd3;
                    off = extend_index(index_value, option,
                                       scaled ? {1'b0, size} : 3'd0);
                end
                else if (inst[10])
                begin
                    ok   = int_ok;
                    off  = imm9_ext;
                    post = !pre;
                    wbv  = 1'b1;
                end
                else
                begin
                    ok  = int_ok && !pre;
                    off = imm9_ext;
                end
            end
            GRP_INT_UOFF:
            begin
                ok   = int_ok;
                blog = {1'b0, size};
                ld   = int_ld;
                sx   = opc[1];
                d64  = int_d64;
                off  = imm12_ext << size;
            end
            GRP_SIMD_REG:
            begin
                vec  = 1'b1;
                ld   = load;
                blog = vscale;
                if (inst[21])
                begin
                    ok  = inst[11:10] == REG_OFF_FORM && vscale <= MAX_LOG_BYTES &&
                          option[1];
                    off = extend_index(index_value, option, scaled ? vscale : 3'd0);
                end
                else if (inst[10])
                begin
                    ok   = vscale <= MAX_LOG_BYTES;
                    off  = imm9_ext;
                    post = !pre;
                    wbv  = 1'b1;
                end
                else
                begin
                    ok  = vscale <= MAX_LOG_BYTES && !pre;
                    off = imm9_ext;
                end
            end
            GRP_SIMD_UOFF:
            begin
                ok   = vscale <= MAX_LOG_BYTES;
                vec  = 1'b1;
                ld   = load;
                blog = vscale;
                off  = imm12_ext << vscale;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // One adder serves the access address and the writeback value.
    assign sum = (use_pc ? pc : base_value) + off;

    always_comb
    begin
        plan = '0;
        if (!ok)
        begin
            plan.status = STATUS_REJECT;
        end
        else if (prefetch)
        begin
            plan.status = STATUS_PREFETCH;
        end
        else
        begin
            plan.status          = STATUS_ACCESS;
            plan.is_load         = ld;
            plan.is_vector       = vec;
            plan.address         = post ? base_value : sum;
            plan.byte_count      = 5'd1 << blog;
            plan.reg_num         = rt;
            plan.reg_num2        = rt2;
            plan.sign_extend     = sx;
            plan.dest_is_64      = d64;
            plan.writeback_valid = wbv;
            plan.writeback_value = wbv ? sum : 64'd0;
            plan.pair            = pair;
        end
    end

endmodule

`default_nettype wire

// ----- src/a64lsu_queue.sv -----
// Plan queue that decouples the decoder from the result issue stage.
`default_nettype none

module a64lsu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire a64lsu_pkg::plan_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output a64lsu_pkg::plan_t      rd_data,
    output logic                   empty
);
    import a64lsu_pkg::*;

    plan_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/a64lsu_back.sv -----
// Back end: issues one or two result transactions per plan into the output register.
`default_nettype none

module a64lsu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire a64lsu_pkg::plan_t q_plan,
    input  wire logic              q_empty,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output a64lsu_pkg::result_t    result
);
    import a64lsu_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    half_reg;
    logic    half_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    out_ready;
    logic    load_out;

    assign out_ready = !out_valid_reg || pop;
    assign load_out  = out_ready && !q_empty;

    // A pair stays at the queue head until its second access has been issued.
    assign q_pop = load_out && (!q_plan.pair || half_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        half_next      = half_reg;
        if (out_ready)
        begin
            out_valid_next = !q_empty;
        end
        if (load_out)
        begin
            half_next = q_plan.pair && !half_reg;
        end
    end

    always_comb
    begin
        out_data_next.status          = q_plan.status;
        out_data_next.is_load         = q_plan.is_load;
        out_data_next.is_vector       = q_plan.is_vector;
        out_data_next.address         = half_reg ? q_plan.address + {59'd0, q_plan.byte_count}
                                                 : q_plan.address;
        out_data_next.byte_count      = q_plan.byte_count;
        out_data_next.reg_num         = half_reg ? q_plan.reg_num2 : q_plan.reg_num;
        out_data_next.sign_extend     = q_plan.sign_extend;
        out_data_next.dest_is_64      = q_plan.dest_is_64;
        out_data_next.writeback_valid = q_plan.writeback_valid;
        out_data_next.writeback_value = q_plan.writeback_value;
        out_data_next.last            = !q_plan.pair || half_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_data_reg;

endmodule

`default_nettype wire

// ----- src/a64_load_store_address_unit_top.sv -----
// Top level of the A64 load/store address unit.
// Usage: an instruction word, its PC, the base register value and the index
// register value enter as one transaction through push/full. Each instruction
// yields one result transaction, or two for a register pair, read through
// empty/pop; the oldest result is on the ports whenever empty is low, and the
// final result of an instruction carries last.
// A result reaches the ports through the plan queue and then the output
// register when nothing waits ahead of it. Throughput is one instruction per
// cycle while the receiver pops, with one output slot per access of a pair.
// The decoder and its address adder sit in front of a four-entry plan queue,
// and the issue stage drains the queue into a single output register; full
// rises only when that queue holds four plans.
// When the receiver stalls, the output register holds its transaction and
// the queue absorbs up to four more instructions before full is raised.
// Reset empties the queue and the output register; the block has no other
// state and is ready to accept an instruction in the first cycle after reset.
`default_nettype none

module a64_load_store_address_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] inst,
    input  wire logic [63:0] pc,
    input  wire logic [63:0] base_value,
    input  wire logic [63:0] index_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic             is_load,
    output logic             is_vector,
    output logic [63:0]      address,
    output logic [4:0]       byte_count,
    output logic [4:0]       reg_num,
    output logic             sign_extend,
    output logic             dest_is_64,
    output logic             writeback_valid,
    output logic [63:0]      writeback_value,
    output logic             last
);
    import a64lsu_pkg::*;

    plan_t   front_plan;
    plan_t   q_plan;
    logic    q_empty;
    logic    q_pop;
    result_t result;

    a64lsu_front u_front (
        .inst        (inst),
        .pc          (pc),
        .base_value  (base_value),
        .index_value (index_value),
        .plan        (front_plan)
    );

    a64lsu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_plan),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_plan),
        .empty   (q_empty)
    );

    a64lsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_plan  (q_plan),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign status          = result.status;
    assign is_load         = result.is_load;
    assign is_vector       = result.is_vector;
    assign address         = result.address;
    assign byte_count      = result.byte_count;
    assign reg_num         = result.reg_num;
    assign sign_extend     = result.sign_extend;
    assign dest_is_64      = result.dest_is_64;
    assign writeback_valid = result.writeback_valid;
    assign writeback_value = result.writeback_value;
    assign last            = result.last;

`ifndef SYNTH
    // The first access of a pair is always followed at once by the second one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> (!empty && last))
        else $error("second access of a pair did not follow the first");

    // Both accesses of a pair carry the same writeback and size, and the second address follows the first by that size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=>
            (writeback_valid == $past(writeback_valid) &&
             byte_count == $past(byte_count) &&
             address == $past(address) + {59'd0, $past(byte_count)}))
        else $error("pair accesses disagree");

    // Only a memory access can be the first half of a pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (status == STATUS_ACCESS))
        else $error("non-final transaction without a memory access");
`endif

endmodule

`default_nettype wire
